// File: rtl/fmpf_pkg.sv
// ----------------------------------------------------------------------------
// fmpf_pkg
// Types and constants shared by the first-match packet filter modules.
// ----------------------------------------------------------------------------
`default_nettype none
package fmpf_pkg;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int CNT_W  = 32;
    localparam int SLOT_OUT_W = 9;

    // request kinds
    typedef enum logic [2:0] {
        K_EVAL   = 3'd0,
        K_ADD_AL = 3'd1,
        K_ADD_DN = 3'd2,
        K_REMOVE = 3'd3,
        K_TOGGLE = 3'd4,
        K_STATS  = 3'd5,
        K_RSVD6  = 3'd6,
        K_RSVD7  = 3'd7
    } t_kind;

    // protocol codes
    localparam logic [1:0] PROTO_ANY = 2'd0;
    localparam logic [1:0] PROTO_TCP = 2'd1;
    localparam logic [1:0] PROTO_UDP = 2'd2;

    // statistics counter ids
    localparam logic [1:0] CID_IN_CHK  = 2'd0;
    localparam logic [1:0] CID_EG_CHK  = 2'd1;
    localparam logic [1:0] CID_IN_DENY = 2'd2;
    localparam logic [1:0] CID_EG_DENY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SEL,
        ST_STATS
    } t_state;

    // request broadcast to every cell
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         slot;
        logic               dir;
        logic [1:0]         proto;
        logic [ADDR_W-1:0]  sa;
        logic [ADDR_W-1:0]  da;
        logic [ADDR_W-1:0]  smask;
        logic [ADDR_W-1:0]  dmask;
        logic [PORT_W-1:0]  sp_lo;
        logic [PORT_W-1:0]  sp_hi;
        logic [PORT_W-1:0]  dp_lo;
        logic [PORT_W-1:0]  dp_hi;
    } t_cmd;

    // per-cycle strobes from the sequencer to the cells
    typedef struct packed {
        logic capture;  // register candidate bit, apply remove/toggle
        logic commit;   // selected cell bumps its count or takes the new rule
    } t_cell_ctl;

    // prefix mask from a length, lengths above 32 act as 32
    function automatic logic [ADDR_W-1:0] mask_of(input logic [5:0] len);
        logic [5:0] l;
        l = (len > 6'd32) ? 6'd32 : len;
        return ~({ADDR_W{1'b1}} >> l);
    endfunction

endpackage
`default_nettype wire

// File: rtl/fmpf_cell.sv
// ----------------------------------------------------------------------------
// fmpf_cell
// One rule slot: stores the rule and its hit count, matches it against the
// broadcast request and takes part in the lowest-slot priority chain.
// ----------------------------------------------------------------------------
`default_nettype none
module fmpf_cell #(
    parameter int IDX = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  fmpf_pkg::t_cmd               i_cmd,
    input  fmpf_pkg::t_cell_ctl          i_ctl,
    input  wire                          i_prior,
    output logic                         o_prior,
    output logic                         o_sel,
    output logic                         o_deny,
    output logic [fmpf_pkg::CNT_W-1:0]   o_hits
);

    logic                            r_active, r_dir, r_deny;
    logic [1:0]                      r_proto;
    logic [fmpf_pkg::ADDR_W-1:0]     r_sa, r_da, r_smask, r_dmask;
    logic [fmpf_pkg::PORT_W-1:0]     r_sp_lo, r_sp_hi, r_dp_lo, r_dp_hi;
    logic [fmpf_pkg::CNT_W-1:0]      r_hits;
    logic                            r_cand;
    logic                            match, ports_ok, is_eval, is_add, slot_hit;

    assign is_eval  = (i_cmd.kind == fmpf_pkg::K_EVAL);
    assign is_add   = (i_cmd.kind == fmpf_pkg::K_ADD_AL) || (i_cmd.kind == fmpf_pkg::K_ADD_DN);
    assign slot_hit = ({1'b0, i_cmd.slot} == 9'(IDX));

    // rule against packet; ports count only for tcp and udp
    always_comb begin
        ports_ok = (i_cmd.sp_lo >= r_sp_lo) && (i_cmd.sp_lo <= r_sp_hi) &&
                   (i_cmd.dp_lo >= r_dp_lo) && (i_cmd.dp_lo <= r_dp_hi);
        match = r_active && (r_dir == i_cmd.dir) &&
                ((r_proto == fmpf_pkg::PROTO_ANY) || (r_proto == i_cmd.proto)) &&
                (((r_sa ^ i_cmd.sa) & r_smask) == '0) &&
                (((r_da ^ i_cmd.da) & r_dmask) == '0) &&
                (!((i_cmd.proto == fmpf_pkg::PROTO_TCP) ||
                   (i_cmd.proto == fmpf_pkg::PROTO_UDP)) || ports_ok);
    end

    // priority chain: first candidate from slot zero upward wins
    assign o_sel   = r_cand && !i_prior;
    assign o_prior = r_cand || i_prior;
    assign o_deny  = r_deny;
    assign o_hits  = r_hits;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_dir    <= 1'b0;
            r_deny   <= 1'b0;
            r_proto  <= '0;
            r_hits   <= '0;
            r_cand   <= 1'b0;
        end else begin
            if (i_ctl.capture) begin
                r_cand <= is_eval ? match : !r_active;
                if (slot_hit && i_cmd.kind == fmpf_pkg::K_REMOVE) begin
                    r_active <= 1'b0;
                    r_hits   <= '0;
                end
                if (slot_hit && i_cmd.kind == fmpf_pkg::K_TOGGLE) begin
                    r_active <= !r_active;
                end
            end
            if (i_ctl.commit && o_sel && is_eval) begin
                r_hits <= r_hits + 1'b1;
            end
            if (i_ctl.commit && o_sel && is_add) begin
                r_active <= 1'b1;
                r_dir    <= i_cmd.dir;
                r_proto  <= i_cmd.proto;
                r_deny   <= (i_cmd.kind == fmpf_pkg::K_ADD_DN);
                r_hits   <= '0;
            end
        end
    end

    // rule payload, valid once written by an add
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && o_sel && is_add) begin
            r_sa    <= i_cmd.sa;
            r_da    <= i_cmd.da;
            r_smask <= i_cmd.smask;
            r_dmask <= i_cmd.dmask;
            r_sp_lo <= i_cmd.sp_lo;
            r_sp_hi <= i_cmd.sp_hi;
            r_dp_lo <= i_cmd.dp_lo;
            r_dp_hi <= i_cmd.dp_hi;
        end
    end

endmodule
`default_nettype wire

// File: rtl/first_match_packet_filter_core.sv
// ----------------------------------------------------------------------------
// first_match_packet_filter_core
// First-match five-tuple packet filter built as a row of rule cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: evaluate,
//   add allow, add deny, remove, toggle or read stats. Output channel
//   (o_out_valid / i_out_stall) carries result items; o_last marks the
//   final one of a request. Defaults are written on the i_cfg_* port.
// Timing:
//   A request is taken in idle, cells register their candidate bit in the
//   next cycle, and in the select state, once the output register is free,
//   the ripple priority chain picks the lowest slot and the result lands in
//   the output register. Remove, toggle and unused kinds return to idle
//   with no result. Stats results follow one per cycle while the output is
//   not stalled.
//   A new request is taken while a result still sits in the output register.
// Reset: all rules inactive, hit counts, traffic counters and defaults zero.
// Stall: the output register holds; a pending result waits in place and the
//   input side stays stalled until it can be loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module first_match_packet_filter_core #(
    parameter int RULES = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_index,
    input  wire                 i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [2:0]          i_kind,
    input  wire  [7:0]          i_rule_slot,
    input  wire                 i_direction,
    input  wire  [1:0]          i_protocol,
    input  wire  [31:0]         i_source_address,
    input  wire  [31:0]         i_dest_address,
    input  wire  [5:0]          i_source_prefix_len,
    input  wire  [5:0]          i_dest_prefix_len,
    input  wire  [15:0]         i_source_port_low,
    input  wire  [15:0]         i_source_port_high,
    input  wire  [15:0]         i_dest_port_low,
    input  wire  [15:0]         i_dest_port_high,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic                o_deny,
    output logic [8:0]          o_slot_index,
    output logic [31:0]         o_count_value,
    output logic [1:0]          o_count_id,
    output logic                o_last
);

    localparam int CW = fmpf_pkg::CNT_W;

    fmpf_pkg::t_state    r_state, n_state;
    fmpf_pkg::t_cmd      r_cmd;
    fmpf_pkg::t_cell_ctl ctl;
    logic                r_def_in, r_def_eg;
    logic [CW-1:0]       r_ctr [4];
    logic [1:0]          r_sid;
    logic                r_out_valid, r_deny, r_last;
    logic [8:0]          r_slot;
    logic [CW-1:0]       r_count;
    logic [1:0]          r_cid;

    logic [RULES:0]      prior;
    logic [RULES-1:0]    sel, cdeny;
    logic [CW-1:0]       hits [RULES];
    logic                accept, out_free, load_sel, load_stat, is_eval, any, sel_deny, verdict;
    logic [8:0]          enc;
    logic [CW-1:0]       sel_hits;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_eval  = (r_cmd.kind == fmpf_pkg::K_EVAL);

    // row of rule cells
    assign prior[0] = 1'b0;
    for (genvar g = 0; g < RULES; g++) begin : g_cell
        fmpf_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_ctl   (ctl),
            .i_prior (prior[g]),
            .o_prior (prior[g+1]),
            .o_sel   (sel[g]),
            .o_deny  (cdeny[g]),
            .o_hits  (hits[g])
        );
    end
    assign any = prior[RULES];

    // one-hot select to slot, count and action
    always_comb begin
        enc      = '0;
        sel_hits = '0;
        sel_deny = 1'b0;
        for (int i = 0; i < RULES; i++) begin
            if (sel[i]) begin
                enc      = enc | 9'(i);
                sel_hits = sel_hits | hits[i];
                sel_deny = sel_deny | cdeny[i];
            end
        end
        verdict = any ? sel_deny : (r_cmd.dir ? r_def_eg : r_def_in);
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        ctl.capture = 1'b0;
        ctl.commit  = 1'b0;
        load_sel    = 1'b0;
        load_stat   = 1'b0;
        unique case (r_state)
            fmpf_pkg::ST_IDLE: begin
                if (accept) n_state = fmpf_pkg::ST_MATCH;
            end
            fmpf_pkg::ST_MATCH: begin
                ctl.capture = 1'b1;
                case (r_cmd.kind) inside
                    fmpf_pkg::K_EVAL, fmpf_pkg::K_ADD_AL, fmpf_pkg::K_ADD_DN:
                        n_state = fmpf_pkg::ST_SEL;
                    fmpf_pkg::K_STATS: n_state = fmpf_pkg::ST_STATS;
                    default:           n_state = fmpf_pkg::ST_IDLE;
                endcase
            end
            fmpf_pkg::ST_SEL: begin
                if (out_free) begin
                    ctl.commit = 1'b1;
                    load_sel   = 1'b1;
                    n_state    = fmpf_pkg::ST_IDLE;
                end
            end
            fmpf_pkg::ST_STATS: begin
                if (out_free) begin
                    load_stat = 1'b1;
                    if (r_sid == fmpf_pkg::CID_EG_DENY) n_state = fmpf_pkg::ST_IDLE;
                end
            end
            default: n_state = fmpf_pkg::ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != fmpf_pkg::ST_IDLE);

    // state, defaults, counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fmpf_pkg::ST_IDLE;
            r_def_in    <= 1'b0;
            r_def_eg    <= 1'b0;
            r_sid       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) r_ctr[i] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index) r_def_eg <= i_cfg_wdata;
                else             r_def_in <= i_cfg_wdata;
            end
            if (load_sel && is_eval) begin
                r_ctr[{1'b0, r_cmd.dir}] <= r_ctr[{1'b0, r_cmd.dir}] + 1'b1;
                if (verdict) r_ctr[{1'b1, r_cmd.dir}] <= r_ctr[{1'b1, r_cmd.dir}] + 1'b1;
            end
            if (load_stat) r_sid <= r_sid + 1'b1;
            if (load_sel || load_stat) r_out_valid <= 1'b1;
            else if (!i_out_stall)     r_out_valid <= 1'b0;
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.kind  <= fmpf_pkg::t_kind'(i_kind);
            r_cmd.slot  <= i_rule_slot;
            r_cmd.dir   <= i_direction;
            r_cmd.proto <= i_protocol;
            r_cmd.sa    <= i_source_address;
            r_cmd.da    <= i_dest_address;
            r_cmd.smask <= fmpf_pkg::mask_of(i_source_prefix_len);
            r_cmd.dmask <= fmpf_pkg::mask_of(i_dest_prefix_len);
            r_cmd.sp_lo <= i_source_port_low;
            r_cmd.sp_hi <= i_source_port_high;
            r_cmd.dp_lo <= i_dest_port_low;
            r_cmd.dp_hi <= i_dest_port_high;
        end
        if (load_sel) begin
            r_deny  <= is_eval ? verdict : 1'b0;
            r_slot  <= any ? enc : 9'(RULES);
            r_count <= (is_eval && any) ? sel_hits + 1'b1 : '0;
            r_cid   <= fmpf_pkg::CID_IN_CHK;
            r_last  <= 1'b1;
        end
        if (load_stat) begin
            r_deny  <= 1'b0;
            r_slot  <= '0;
            r_count <= r_ctr[r_sid];
            r_cid   <= r_sid;
            r_last  <= (r_sid == fmpf_pkg::CID_EG_DENY);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_deny        = r_deny;
    assign o_slot_index  = r_slot;
    assign o_count_value = r_count;
    assign o_count_id    = r_cid;
    assign o_last        = r_last;

endmodule
`default_nettype wire

// File: rtl/fmpf_checker.sv
// ----------------------------------------------------------------------------
// fmpf_checker
// Port-level checks on the filter's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module fmpf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire        o_deny,
    input wire [8:0]  o_slot_index,
    input wire [31:0] o_count_value,
    input wire [1:0]  o_count_id,
    input wire        o_last
);

    // a stalled result stays and holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_count_value)
        && $stable(o_slot_index))
        else $error("stalled result changed");

    // stats results carry no verdict and slot zero
    a_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_count_id != 2'd0 |-> !o_deny && o_slot_index == 9'd0)
        else $error("stats result with verdict or slot");

    // only the last stats counter closes a multi-result request
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_count_id == 2'd3 |-> o_last)
        else $error("final stats result not marked last");

    // a non-final result is a stats item, which follows on the next transfer
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid &&
        o_count_id == $past(o_count_id) + 2'd1)
        else $error("stats results out of order");

endmodule

bind first_match_packet_filter_core fmpf_checker u_fmpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_deny        (o_deny),
    .o_slot_index  (o_slot_index),
    .o_count_value (o_count_value),
    .o_count_id    (o_count_id),
    .o_last        (o_last)
);
`default_nettype wire

// File: test/first_match_packet_filter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_match_packet_filter_core_test
// Drives rule adds, removes, toggles, packet evaluations and stats reads into
// the filter core with random idle bursts on both channels. A shadow rule
// table predicts every result, which is compared field by field on output.
// ----------------------------------------------------------------------------
`default_nettype none
module first_match_packet_filter_core_test;

    localparam int NRULES = 32;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  slot;
        logic        dir;
        logic [1:0]  proto;
        logic [31:0] sa;
        logic [31:0] da;
        logic [5:0]  slen;
        logic [5:0]  dlen;
        logic [15:0] sp_lo;
        logic [15:0] sp_hi;
        logic [15:0] dp_lo;
        logic [15:0] dp_hi;
    } t_req;

    typedef struct packed {
        logic        deny;
        logic [8:0]  slot;
        logic [31:0] count;
        logic [1:0]  id;
        logic        last;
    } t_res;

    typedef struct {
        logic        active;
        logic        dir;
        logic [1:0]  proto;
        logic        deny;
        logic        written;
        logic [31:0] sa;
        logic [31:0] da;
        logic [5:0]  slen;
        logic [5:0]  dlen;
        logic [15:0] sp_lo;
        logic [15:0] sp_hi;
        logic [15:0] dp_lo;
        logic [15:0] dp_hi;
        logic [31:0] hits;
    } t_rule;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_req        req = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_res        res;

    t_rule       rule_tab [NRULES];
    logic [31:0] traffic [4];
    logic        dflt_in_deny, dflt_eg_deny;

    t_req        pending_reqs [$];
    t_res        expected_results [$];
    int          errors = 0;
    int          in_idle_left = 0, out_idle_left = 0;
    bit          quiet = 1'b0;
    int          stuck_cycles = 0;

    // shadow of what the stimulus generator assumes about the table
    bit          slot_written [NRULES];
    bit          plan_active [NRULES];
    t_req        plan_rule [NRULES];

    always #10 clk = ~clk;

    first_match_packet_filter_core #(.RULES(NRULES)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(req.kind), .i_rule_slot(req.slot), .i_direction(req.dir),
        .i_protocol(req.proto), .i_source_address(req.sa),
        .i_dest_address(req.da), .i_source_prefix_len(req.slen),
        .i_dest_prefix_len(req.dlen), .i_source_port_low(req.sp_lo),
        .i_source_port_high(req.sp_hi), .i_dest_port_low(req.dp_lo),
        .i_dest_port_high(req.dp_hi),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_deny(res.deny), .o_slot_index(res.slot), .o_count_value(res.count),
        .o_count_id(res.id), .o_last(res.last)
    );

    function automatic logic [31:0] prefix_mask(logic [5:0] len);
        if (len == 0) return 32'h0;
        if (len >= 32) return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic bit rule_matches(int i, t_req p);
        t_rule r;
        r = rule_tab[i];
        if (!r.active || r.dir != p.dir) return 0;
        if (r.proto != fmpf_pkg::PROTO_ANY && r.proto != p.proto) return 0;
        if (((r.sa ^ p.sa) & prefix_mask(r.slen)) != 0) return 0;
        if (((r.da ^ p.da) & prefix_mask(r.dlen)) != 0) return 0;
        if (p.proto == fmpf_pkg::PROTO_TCP || p.proto == fmpf_pkg::PROTO_UDP) begin
            if (p.sp_lo < r.sp_lo || p.sp_lo > r.sp_hi) return 0;
            if (p.dp_lo < r.dp_lo || p.dp_lo > r.dp_hi) return 0;
        end
        return 1;
    endfunction

    // classify one request against the shadow table, queue its results
    task automatic classify(t_req p);
        t_res o;
        int   hit;
        o = '0;
        o.last = 1'b1;
        case (fmpf_pkg::t_kind'(p.kind))
            fmpf_pkg::K_EVAL: begin
                traffic[p.dir] += 1;
                hit = -1;
                for (int i = 0; i < NRULES; i++)
                    if (hit < 0 && rule_matches(i, p)) hit = i;
                if (hit >= 0) begin
                    rule_tab[hit].hits += 1;
                    o.deny = rule_tab[hit].deny;
                    o.slot = 9'(hit);
                    o.count = rule_tab[hit].hits;
                end else begin
                    o.deny = p.dir ? dflt_eg_deny : dflt_in_deny;
                    o.slot = 9'(NRULES);
                end
                if (o.deny) traffic[2 + p.dir] += 1;
                expected_results.push_back(o);
            end
            fmpf_pkg::K_ADD_AL, fmpf_pkg::K_ADD_DN: begin
                hit = -1;
                for (int i = 0; i < NRULES; i++)
                    if (hit < 0 && !rule_tab[i].active) hit = i;
                o.slot = (hit < 0) ? 9'(NRULES) : 9'(hit);
                if (hit >= 0) begin
                    rule_tab[hit] = '{1'b1, p.dir, p.proto, p.kind == fmpf_pkg::K_ADD_DN,
                                      1'b1, p.sa, p.da, p.slen, p.dlen, p.sp_lo, p.sp_hi,
                                      p.dp_lo, p.dp_hi, 32'h0};
                end
                expected_results.push_back(o);
            end
            fmpf_pkg::K_REMOVE: if (p.slot < NRULES) begin
                rule_tab[p.slot].active = 1'b0;
                rule_tab[p.slot].hits = 0;
            end
            fmpf_pkg::K_TOGGLE: if (p.slot < NRULES)
                rule_tab[p.slot].active = ~rule_tab[p.slot].active;
            fmpf_pkg::K_STATS: for (int i = 0; i < 4; i++) begin
                o = '0;
                o.count = traffic[i];
                o.id = 2'(i);
                o.last = (i == 3);
                expected_results.push_back(o);
            end
            default: ;
        endcase
    endtask

    function automatic t_req random_req();
        t_req p;
        p = t_req'($bits(t_req)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom}));
        p.slen = 6'($urandom_range(0, 63));
        p.dlen = 6'($urandom_range(0, 63));
        return p;
    endfunction

    // random rule with short prefixes and wide port ranges so packets match
    function automatic t_req rule_req();
        t_req p;
        logic [15:0] a, b;
        p = random_req();
        p.kind = $urandom_range(0, 1) ? fmpf_pkg::K_ADD_DN : fmpf_pkg::K_ADD_AL;
        p.slen = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 12));
        p.dlen = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 12));
        a = 16'($urandom); b = 16'($urandom);
        if ($urandom_range(0, 5) != 0) begin
            p.sp_lo = (a < b) ? a : b; p.sp_hi = (a < b) ? b : a;
        end
        a = 16'($urandom); b = 16'($urandom);
        if ($urandom_range(0, 5) != 0) begin
            p.dp_lo = (a < b) ? a : b; p.dp_hi = (a < b) ? b : a;
        end
        return p;
    endfunction

    task automatic plan(t_req p);
        int idx;
        if (p.kind == fmpf_pkg::K_ADD_AL || p.kind == fmpf_pkg::K_ADD_DN) begin
            idx = -1;
            for (int i = 0; i < NRULES; i++)
                if (idx < 0 && !plan_active[i]) idx = i;
            if (idx >= 0) begin
                plan_active[idx] = 1; slot_written[idx] = 1; plan_rule[idx] = p;
            end
        end else if (p.kind == fmpf_pkg::K_REMOVE && p.slot < NRULES) begin
            plan_active[p.slot] = 0;
        end else if (p.kind == fmpf_pkg::K_TOGGLE && p.slot < NRULES) begin
            plan_active[p.slot] = ~plan_active[p.slot];
        end
        pending_reqs.push_back(p);
    endtask

    // input driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                classify(req);
                void'(pending_reqs.pop_front());
            end
            if (!(in_valid && in_stall)) begin
                if (in_idle_left > 0) begin
                    in_idle_left <= in_idle_left - 1;
                    in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    in_idle_left <= $urandom_range(0, 17);
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_valid <= 1'b1;
                    req <= pending_reqs[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and stall generator
    always @(posedge clk) begin
        t_res x;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, res);
                    errors++;
                end else begin
                    x = expected_results.pop_front();
                    if (res.deny !== x.deny)
                        $display("%0t: deny expected %0d actual %0d", $time, x.deny, res.deny);
                    if (res.slot !== x.slot)
                        $display("%0t: slot expected %0d actual %0d", $time, x.slot, res.slot);
                    if (res.count !== x.count)
                        $display("%0t: count expected %0d actual %0d", $time, x.count,
                                 res.count);
                    if (res.id !== x.id)
                        $display("%0t: count_id expected %0d actual %0d", $time, x.id, res.id);
                    if (res.last !== x.last)
                        $display("%0t: last expected %0d actual %0d", $time, x.last, res.last);
                    if (res !== x) errors++;
                end
            end
            if (out_idle_left > 0) begin
                out_idle_left <= out_idle_left - 1;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_idle_left <= $urandom_range(0, 17);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
            // watchdog on transfers
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                    || (pending_reqs.size() == 0 && expected_results.size() == 0))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx) dflt_eg_deny = val; else dflt_in_deny = val;
    endtask

    task automatic directed();
        t_req p;
        // rule 0: tcp ingress /24 with port range, allow
        p = '0; p.kind = fmpf_pkg::K_ADD_AL; p.proto = fmpf_pkg::PROTO_TCP;
        p.sa = 32'hC0A8_0100; p.slen = 6'd24; p.da = 32'hFFFF_FFFF; p.dlen = 6'd0;
        p.sp_lo = 16'd1000; p.sp_hi = 16'd2000; p.dp_lo = 16'd0; p.dp_hi = 16'hFFFF;
        plan(p);
        // rule 1: egress any-protocol exact host, prefix above 32, deny
        p = '0; p.kind = fmpf_pkg::K_ADD_DN; p.dir = 1'b1; p.sa = 32'h0A00_0001;
        p.slen = 6'd63; p.da = 32'hFFFF_FFFF; p.dlen = 6'd32; p.sp_lo = 16'hFFFF;
        p.sp_hi = 16'h0; p.dp_hi = 16'hFFFF; plan(p);
        // rule 2: icmp ingress catch-all, deny
        p = '0; p.kind = fmpf_pkg::K_ADD_DN; p.proto = 2'd3; p.sa = 32'hFFFF_FFFF;
        p.da = 32'hFFFF_FFFF; p.sp_lo = 16'hFFFF; p.sp_hi = 16'hFFFF;
        p.dp_lo = 16'hFFFF; p.dp_hi = 16'hFFFF; plan(p);
        // packets: in range, port edges, out of range, default, icmp ignoring ports
        p = '0; p.kind = fmpf_pkg::K_EVAL; p.proto = fmpf_pkg::PROTO_TCP;
        p.sa = 32'hC0A8_01FF; p.sp_lo = 16'd1000; p.dp_lo = 16'hFFFF; plan(p);
        p.sp_lo = 16'd2000; plan(p);
        p.sp_lo = 16'd2001; plan(p);
        p = '0; p.kind = fmpf_pkg::K_EVAL; p.dir = 1'b1; p.proto = 2'd3;
        p.sa = 32'h0A00_0001; p.da = 32'hFFFF_FFFF; plan(p);
        p.proto = fmpf_pkg::PROTO_UDP; plan(p);
        p = '0; p.kind = fmpf_pkg::K_EVAL; p.proto = 2'd3; p.sa = 32'h1234_5678; plan(p);
        // toggle off and on, remove, out-of-range slots, unused kinds
        p = '0; p.kind = fmpf_pkg::K_TOGGLE; p.slot = 8'd2; plan(p);
        p = '0; p.kind = fmpf_pkg::K_EVAL; p.proto = 2'd3; plan(p);
        p = '0; p.kind = fmpf_pkg::K_TOGGLE; p.slot = 8'd2; plan(p);
        p = '0; p.kind = fmpf_pkg::K_REMOVE; p.slot = 8'd0; plan(p);
        p = '0; p.kind = fmpf_pkg::K_REMOVE; p.slot = 8'hFF; plan(p);
        p = '0; p.kind = fmpf_pkg::K_TOGGLE; p.slot = 8'(NRULES); plan(p);
        p = '1; p.kind = fmpf_pkg::K_RSVD6; plan(p);
        p = '1; p.kind = fmpf_pkg::K_RSVD7; plan(p);
        p = '0; p.kind = fmpf_pkg::K_STATS; plan(p);
        p = '1; p.kind = fmpf_pkg::K_ADD_AL; plan(p);
        p = '1; p.kind = fmpf_pkg::K_EVAL; plan(p);
    endtask

    initial begin
        t_req p;
        int   r, s;
        foreach (rule_tab[i]) rule_tab[i] = '{default: '0};
        foreach (traffic[i]) traffic[i] = 0;
        foreach (plan_active[i]) begin
            plan_active[i] = 0; slot_written[i] = 0;
        end
        dflt_in_deny = 0; dflt_eg_deny = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        drain();
        write_cfg(1'b0, 1'b1);
        write_cfg(1'b1, 1'b1);

        for (int n = 0; n < 180; n++) begin
            if (n == 60 || n == 120) begin
                drain();
                write_cfg(n == 60 ? 1'b0 : 1'b1, 1'b0);
                if (n == 120) write_cfg(1'b0, 1'b1);
            end
            if (n == 150) quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 20) begin
                plan(rule_req());
            end else if (r < 70) begin
                s = $urandom_range(0, NRULES - 1);
                if (slot_written[s]) begin
                    // aim at the planned rule's tuple, not the shadow table
                    p = random_req(); p.kind = fmpf_pkg::K_EVAL;
                    p.dir = plan_rule[s].dir;
                    if (plan_rule[s].proto != fmpf_pkg::PROTO_ANY)
                        p.proto = plan_rule[s].proto;
                    p.sa = (plan_rule[s].sa & prefix_mask(plan_rule[s].slen))
                         | (p.sa & ~prefix_mask(plan_rule[s].slen));
                    p.da = (plan_rule[s].da & prefix_mask(plan_rule[s].dlen))
                         | (p.da & ~prefix_mask(plan_rule[s].dlen));
                    if (plan_rule[s].sp_lo <= plan_rule[s].sp_hi)
                        p.sp_lo = 16'($urandom_range(plan_rule[s].sp_lo,
                                                     plan_rule[s].sp_hi));
                    if (plan_rule[s].dp_lo <= plan_rule[s].dp_hi)
                        p.dp_lo = 16'($urandom_range(plan_rule[s].dp_lo,
                                                     plan_rule[s].dp_hi));
                end else begin
                    p = random_req(); p.kind = fmpf_pkg::K_EVAL;
                end
                plan(p);
            end else if (r < 85) begin
                p = random_req(); p.kind = fmpf_pkg::K_REMOVE;
                if ($urandom_range(0, 4) != 0) p.slot = 8'($urandom_range(0, NRULES - 1));
                plan(p);
            end else if (r < 93) begin
                // toggle only slots holding a written rule, or out of range
                p = random_req(); p.kind = fmpf_pkg::K_TOGGLE;
                s = $urandom_range(0, NRULES - 1);
                if (slot_written[s]) p.slot = 8'(s);
                else p.slot = 8'($urandom_range(NRULES, 255));
                plan(p);
            end else if (r < 97) begin
                p = random_req(); p.kind = fmpf_pkg::K_STATS; plan(p);
            end else begin
                p = random_req();
                p.kind = $urandom_range(0, 1) ? fmpf_pkg::K_RSVD6 : fmpf_pkg::K_RSVD7;
                plan(p);
            end
        end
        p = '0; p.kind = fmpf_pkg::K_STATS; plan(p);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
rtl/fmpf_pkg.sv
rtl/fmpf_cell.sv
rtl/first_match_packet_filter_core.sv
rtl/fmpf_checker.sv
test/first_match_packet_filter_core_test.sv
